// ===== rtl/block_aligned_range_splitter_core_assert.svh =====
// Assertion macros for the range splitter checker.
`ifndef BLOCK_ALIGNED_RANGE_SPLITTER_CORE_ASSERT_SVH
`define BLOCK_ALIGNED_RANGE_SPLITTER_CORE_ASSERT_SVH

// Clocked assertion, disabled while reset is asserted.
`define BRS_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("%m: assertion failed");

// Clocked assertion that also holds during reset.
`define BRS_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("%m: assertion failed");

`endif

// ===== rtl/brs_pkg.sv =====
`timescale 1ns / 1ps

package brs_pkg;

  localparam int MaxRangesDefault = 64;
  localparam int DivSteps         = 64;

  localparam logic [31:0] BlockSizeReset = 32'd4096;
  localparam logic [63:0] MaxRangeReset  = 64'd1048576;

  localparam logic CFG_BLOCK_SIZE = 1'b0;
  localparam logic CFG_MAX_RANGE  = 1'b1;

  localparam logic [2:0] ST_RANGE           = 3'd0;
  localparam logic [2:0] ST_ZERO_LIMIT      = 3'd1;
  localparam logic [2:0] ST_BLOCK_TOO_LARGE = 3'd2;
  localparam logic [2:0] ST_NOTHING         = 3'd3;
  localparam logic [2:0] ST_TRUNCATED       = 3'd4;

  typedef enum logic [1:0] {
    SEL_OFF,
    SEL_END,
    SEL_MAX
  } brs_sel_e;

  typedef struct packed {
    logic     load;
    logic     cap_end;
    logic     div_start;
    brs_sel_e div_sel;
    logic     cap_begin;
    logic     cap_pad;
    logic     cap_full;
    logic     cap_aend;
    logic     init;
    logic     emit_err;
    logic     emit_range;
  } brs_cmd_t;

  typedef struct packed {
    logic err;
    logic div_done;
    logic split_last;
  } brs_stat_t;

endpackage

// ===== rtl/brs_div.sv =====
`timescale 1ns / 1ps

module brs_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic        done_o,
  output logic [31:0] rem_o
);
  import brs_pkg::*;

  localparam int CntW = $clog2(DivSteps);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [63:0]     dvd_q, dvd_d;
  logic [31:0]     rem_q, rem_d;
  logic [32:0]     trial;

  // restoring remainder step, one dividend bit per cycle
  assign trial = {rem_q, dvd_q[63]};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = dividend_i;
      rem_d  = '0;
    end else if (busy_q) begin
      dvd_d = {dvd_q[62:0], 1'b0};
      if (trial >= {1'b0, divisor_i}) begin
        rem_d = 32'(trial - {1'b0, divisor_i});
      end else begin
        rem_d = trial[31:0];
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(DivSteps - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

// ===== rtl/brs_dp.sv =====
`timescale 1ns / 1ps

module brs_dp #(
  parameter int MAX_RANGES = brs_pkg::MaxRangesDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  brs_pkg::brs_cmd_t cmd_i,
  output brs_pkg::brs_stat_t stat_o,
  input  logic [63:0]       object_size_i,
  input  logic [63:0]       req_offset_i,
  input  logic [63:0]       req_length_i,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [63:0]       cfg_wdata_i,
  output logic              result_valid_o,
  output logic [63:0]       range_offset_o,
  output logic [63:0]       range_length_o,
  output logic [2:0]        status_o,
  output logic              last_o
);
  import brs_pkg::*;

  localparam int CntW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;

  logic [31:0]     bs_q;
  logic [63:0]     mx_q;
  logic [63:0]     osize_q, off_q, len_q;
  logic [63:0]     end_q, begin_q, full_q, aend_q;
  logic [31:0]     pad_q;
  logic            rem_zero_q;
  logic [63:0]     pos_q, left_q;
  logic [CntW-1:0] cnt_q;

  logic            ovalid_q;
  logic [63:0]     ooff_q, olen_q;
  logic [2:0]      ost_q;
  logic            olast_q;

  logic [63:0] dividend;
  logic [31:0] rem;
  logic        div_done;

  logic        zero_lim, too_big, nothing;
  logic [2:0]  err_code;
  logic [64:0] req_sum, pad_sum;
  logic [63:0] end_d, aend_d;
  logic [63:0] piece;
  logic        full_lt, at_cap, split_last;

  always_comb begin
    case (cmd_i.div_sel)
      SEL_OFF: dividend = off_q;
      SEL_END: dividend = end_q;
      SEL_MAX: dividend = mx_q;
      default: dividend = off_q;
    endcase
  end

  brs_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dividend),
    .divisor_i  (bs_q),
    .done_o     (div_done),
    .rem_o      (rem)
  );

  assign zero_lim = (bs_q == '0) || (mx_q == '0);
  assign too_big  = {32'd0, bs_q} > mx_q;
  assign nothing  = (len_q == '0) || (off_q >= osize_q);

  always_comb begin
    if (zero_lim) begin
      err_code = ST_ZERO_LIMIT;
    end else if (too_big) begin
      err_code = ST_BLOCK_TOO_LARGE;
    end else begin
      err_code = ST_NOTHING;
    end
  end

  // overflowing end falls back to the object size
  assign req_sum = {1'b0, off_q} + {1'b0, len_q};
  assign end_d   = (req_sum[64] || (req_sum[63:0] > osize_q)) ? osize_q : req_sum[63:0];

  assign pad_sum = {1'b0, end_q} + {33'd0, pad_q};
  always_comb begin
    if (rem_zero_q) begin
      aend_d = end_q;
    end else if (pad_sum[64] || (pad_sum[63:0] > osize_q)) begin
      aend_d = osize_q;
    end else begin
      aend_d = pad_sum[63:0];
    end
  end

  assign full_lt    = full_q < left_q;
  assign piece      = full_lt ? full_q : left_q;
  assign at_cap     = (cnt_q == CntW'(MAX_RANGES - 1));
  assign split_last = !full_lt || at_cap;

  assign stat_o.err        = zero_lim || too_big || nothing;
  assign stat_o.div_done   = div_done;
  assign stat_o.split_last = split_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bs_q <= BlockSizeReset;
      mx_q <= MaxRangeReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_BLOCK_SIZE: bs_q <= cfg_wdata_i[31:0];
        CFG_MAX_RANGE:  mx_q <= cfg_wdata_i;
        default:        bs_q <= bs_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      osize_q <= object_size_i;
      off_q   <= req_offset_i;
      len_q   <= req_length_i;
    end
    if (cmd_i.cap_end) begin
      end_q <= end_d;
    end
    if (cmd_i.cap_begin) begin
      begin_q <= off_q - {32'd0, rem};
    end
    if (cmd_i.cap_pad) begin
      pad_q      <= bs_q - rem;
      rem_zero_q <= (rem == '0);
    end
    if (cmd_i.cap_full) begin
      full_q <= mx_q - {32'd0, rem};
    end
    if (cmd_i.cap_aend) begin
      aend_q <= aend_d;
    end
    if (cmd_i.init) begin
      pos_q  <= begin_q;
      left_q <= aend_q - begin_q;
    end else if (cmd_i.emit_range) begin
      pos_q  <= pos_q + piece;
      left_q <= left_q - piece;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.init) begin
      cnt_q <= '0;
    end else if (cmd_i.emit_range && !at_cap) begin
      cnt_q <= cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else begin
      ovalid_q <= cmd_i.emit_err || cmd_i.emit_range;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_err) begin
      ooff_q  <= '0;
      olen_q  <= '0;
      ost_q   <= err_code;
      olast_q <= 1'b1;
    end else if (cmd_i.emit_range) begin
      ooff_q  <= pos_q;
      olen_q  <= piece;
      ost_q   <= (at_cap && full_lt) ? ST_TRUNCATED : ST_RANGE;
      olast_q <= split_last;
    end
  end

  assign result_valid_o = ovalid_q;
  assign range_offset_o = ooff_q;
  assign range_length_o = olen_q;
  assign status_o       = ost_q;
  assign last_o         = olast_q;

endmodule

// ===== rtl/brs_ctrl.sv =====
`timescale 1ns / 1ps

module brs_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  brs_pkg::brs_stat_t stat_i,
  output brs_pkg::brs_cmd_t  cmd_o
);
  import brs_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_CHECK = 8'b0000_0010,
    S_DOFF  = 8'b0000_0100,
    S_DEND  = 8'b0000_1000,
    S_DMAX  = 8'b0001_0000,
    S_ALIGN = 8'b0010_0000,
    S_INIT  = 8'b0100_0000,
    S_SPLIT = 8'b1000_0000
  } brs_state_e;

  brs_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.div_sel = SEL_OFF;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd_o.cap_end = 1'b1;
        if (stat_i.err) begin
          cmd_o.emit_err = 1'b1;
          state_d        = S_IDLE;
        end else begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel   = SEL_OFF;
          state_d         = S_DOFF;
        end
      end
      S_DOFF: begin
        if (stat_i.div_done) begin
          cmd_o.cap_begin = 1'b1;
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel   = SEL_END;
          state_d         = S_DEND;
        end
      end
      S_DEND: begin
        if (stat_i.div_done) begin
          cmd_o.cap_pad   = 1'b1;
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel   = SEL_MAX;
          state_d         = S_DMAX;
        end
      end
      S_DMAX: begin
        if (stat_i.div_done) begin
          cmd_o.cap_full = 1'b1;
          state_d        = S_ALIGN;
        end
      end
      S_ALIGN: begin
        cmd_o.cap_aend = 1'b1;
        state_d        = S_INIT;
      end
      S_INIT: begin
        cmd_o.init = 1'b1;
        state_d    = S_SPLIT;
      end
      S_SPLIT: begin
        cmd_o.emit_range = 1'b1;
        if (stat_i.split_last) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

// ===== rtl/block_aligned_range_splitter_core.sv =====
`timescale 1ns / 1ps

// channel   direction  handshake                     payload
// request   in         start_i high, busy_o low      object_size_i req_offset_i req_length_i
// result    out        result_valid_o, one cycle     range_offset_o range_length_o status_o last_o
// config    in         cfg_we_i                      cfg_idx_i cfg_wdata_i
//
// Error and empty requests: the request is loaded, checked, and one final error result is registered.
// Otherwise three remainder passes (offset, end, max range) on one shared bit-serial divider,
// then the align and init steps, then one range per cycle.
// busy_o stays high until the final result is loaded; results cannot be stalled.
// Reset is asynchronous, active low, and restores the configuration defaults.

module block_aligned_range_splitter_core #(
  parameter int MAX_RANGES = brs_pkg::MaxRangesDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [63:0] object_size_i,
  input  logic [63:0] req_offset_i,
  input  logic [63:0] req_length_i,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [63:0] cfg_wdata_i,
  output logic        result_valid_o,
  output logic [63:0] range_offset_o,
  output logic [63:0] range_length_o,
  output logic [2:0]  status_o,
  output logic        last_o
);
  import brs_pkg::*;

  brs_cmd_t  cmd;
  brs_stat_t stat;

  brs_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .stat_i  (stat),
    .cmd_o   (cmd)
  );

  brs_dp #(
    .MAX_RANGES (MAX_RANGES)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .object_size_i  (object_size_i),
    .req_offset_i   (req_offset_i),
    .req_length_i   (req_length_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .result_valid_o (result_valid_o),
    .range_offset_o (range_offset_o),
    .range_length_o (range_length_o),
    .status_o       (status_o),
    .last_o         (last_o)
  );

endmodule

// ===== rtl/brs_checker.sv =====
`timescale 1ns / 1ps

`include "block_aligned_range_splitter_core_assert.svh"

module brs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start_i,
  input logic        busy_o,
  input logic        result_valid_o,
  input logic [63:0] range_offset_o,
  input logic [63:0] range_length_o,
  input logic [2:0]  status_o,
  input logic        last_o
);
  import brs_pkg::*;

  // a request always takes the block out of idle
  `BRS_ASSERT(a_start_busy, clk_i, rst_ni, (start_i && !busy_o) |=> busy_o)

  // results only come out of a request in progress
  `BRS_ASSERT(a_valid_after_busy, clk_i, rst_ni, result_valid_o |-> $past(busy_o))

  // the final result coincides with the return to idle
  `BRS_ASSERT(a_last_idle, clk_i, rst_ni, result_valid_o |-> (last_o == !busy_o))

  // non-range results are single, final and empty
  `BRS_ASSERT(a_err_shape, clk_i, rst_ni,
              (result_valid_o && status_o != ST_RANGE && status_o != ST_TRUNCATED) |->
              (last_o && range_offset_o == '0 && range_length_o == '0))

  `BRS_ASSERT(a_trunc_last, clk_i, rst_ni,
              (result_valid_o && status_o == ST_TRUNCATED) |-> last_o)

endmodule

bind block_aligned_range_splitter_core brs_checker u_brs_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .busy_o         (busy_o),
  .result_valid_o (result_valid_o),
  .range_offset_o (range_offset_o),
  .range_length_o (range_length_o),
  .status_o       (status_o),
  .last_o         (last_o)
);

// ===== dv/tb_block_aligned_range_splitter_core.sv =====
`timescale 1ns / 1ps

module tb_block_aligned_range_splitter_core;
  import brs_pkg::*;

  localparam int NumRanges = 64;
  localparam logic [63:0] AllOnes = '1;

  typedef struct {
    logic [63:0] rng_off;
    logic [63:0] rng_len;
    logic [2:0]  status;
    logic        last;
  } range_res_t;

  class range_scoreboard;
    range_res_t  pending[$];
    logic [31:0] block_size;
    logic [63:0] max_range;
    int          errors;

    function new();
      block_size = BlockSizeReset;
      max_range  = MaxRangeReset;
      errors     = 0;
    endfunction

    function void load_limits(logic [63:0] bs_data, logic [63:0] mx_data);
      block_size = bs_data[31:0];
      max_range  = mx_data;
    endfunction

    function void push_range(logic [63:0] o, logic [63:0] l, logic [2:0] st, logic lst);
      range_res_t r;
      r.rng_off = o;
      r.rng_len = l;
      r.status  = st;
      r.last    = lst;
      pending.insert(pending.size(), r);
    endfunction

    // Expected ranges for one accepted request.
    function void note_request(logic [63:0] osize, logic [63:0] off, logic [63:0] len);
      logic [63:0] bs, span_end, first_blk, stop_at, rem, pad, chunk, pos, left, piece;
      int k;
      bs = {32'd0, block_size};
      if (bs == 0 || max_range == 0) begin
        push_range('0, '0, ST_ZERO_LIMIT, 1'b1);
        return;
      end
      if (bs > max_range) begin
        push_range('0, '0, ST_BLOCK_TOO_LARGE, 1'b1);
        return;
      end
      if (len == 0 || off >= osize) begin
        push_range('0, '0, ST_NOTHING, 1'b1);
        return;
      end
      span_end = osize;
      if (len <= ~off) begin
        span_end = off + len;
        if (span_end > osize) span_end = osize;
      end
      if (span_end <= off) begin
        push_range('0, '0, ST_NOTHING, 1'b1);
        return;
      end
      first_blk = off - off % bs;
      rem = span_end % bs;
      stop_at = span_end;
      if (rem != 0) begin
        pad = bs - rem;
        stop_at = (span_end <= ~pad) ? span_end + pad : osize;
      end
      if (stop_at > osize) stop_at = osize;
      chunk = (max_range / bs) * bs;
      pos = first_blk;
      k = 0;
      while (pos < stop_at && k < NumRanges) begin
        left = stop_at - pos;
        piece = (chunk < left) ? chunk : left;
        push_range(pos, piece, ST_RANGE, 1'b0);
        pos += piece;
        k++;
      end
      if (k == 0) begin
        push_range('0, '0, ST_NOTHING, 1'b1);
        return;
      end
      if (pos < stop_at) pending[pending.size() - 1].status = ST_TRUNCATED;
      pending[pending.size() - 1].last = 1'b1;
    endfunction

    task report(string msg);
      if (errors < 50) $display("MISMATCH @%0t: %s", $time, msg);
      errors++;
    endtask

    task check_result(logic [63:0] o, logic [63:0] l, logic [2:0] st, logic lst);
      range_res_t exp_r;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result off=%h len=%h st=%0d last=%b", o, l, st, lst));
        return;
      end
      exp_r = pending.pop_front();
      if (o !== exp_r.rng_off || l !== exp_r.rng_len || st !== exp_r.status ||
          lst !== exp_r.last)
        report($sformatf("got off=%h len=%h st=%0d last=%b, exp off=%h len=%h st=%0d last=%b",
                         o, l, st, lst, exp_r.rng_off, exp_r.rng_len, exp_r.status,
                         exp_r.last));
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  logic [63:0] object_size_i = '0;
  logic [63:0] req_offset_i = '0;
  logic [63:0] req_length_i = '0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_idx_i = CFG_BLOCK_SIZE;
  logic [63:0] cfg_wdata_i = '0;
  logic        result_valid_o;
  logic [63:0] range_offset_o;
  logic [63:0] range_length_o;
  logic [2:0]  status_o;
  logic        last_o;

  range_scoreboard sb = new();
  bit idle_on = 1'b1;

  block_aligned_range_splitter_core #(
    .MAX_RANGES(NumRanges)
  ) uut (
    .clk_i,
    .rst_ni,
    .start_i,
    .busy_o,
    .object_size_i,
    .req_offset_i,
    .req_length_i,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_wdata_i,
    .result_valid_o,
    .range_offset_o,
    .range_length_o,
    .status_o,
    .last_o
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o)
      sb.check_result(range_offset_o, range_length_o, status_o, last_o);
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic send_request(logic [63:0] osize, logic [63:0] off, logic [63:0] len);
    while (idle_on && $urandom_range(99) < 34) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i       <= 1'b1;
    object_size_i <= osize;
    req_offset_i  <= off;
    req_length_i  <= len;
    do @(posedge clk_i); while (busy_o);
    sb.note_request(osize, off, len);
  endtask

  task automatic drain();
    start_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Both registers back to back; only called while idle.
  task automatic set_limits(logic [63:0] bs_data, logic [63:0] mx_data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_BLOCK_SIZE;
    cfg_wdata_i <= bs_data;
    @(posedge clk_i);
    cfg_idx_i   <= CFG_MAX_RANGE;
    cfg_wdata_i <= mx_data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.load_limits(bs_data, mx_data);
    @(posedge clk_i);
  endtask

  task automatic random_limits(int kind);
    logic [31:0] bs;
    logic [63:0] mx;
    case (kind)
      0: begin
        bs = 32'd1 << $urandom_range(20);
        mx = 64'(bs) * $urandom_range(1, 32) + $urandom_range(0, bs - 1);
      end
      1: begin
        bs = $urandom_range(1, 5000);
        mx = 64'(bs) * $urandom_range(1, 40) + $urandom_range(0, bs);
      end
      2: begin
        bs = $urandom;
        mx = rand64();
      end
      default: begin
        bs = $urandom_range(1, 1 << 20);
        mx = $urandom_range(1) ? 64'(bs) - 1 : '0;
      end
    endcase
    set_limits({$urandom, bs}, mx);
  endtask

  task automatic random_request();
    logic [63:0] osize, off, len;
    int unsigned pick;
    pick  = $urandom_range(99);
    osize = rand64() >> $urandom_range(63);
    off   = rand64();
    len   = rand64();
    if (pick < 60) begin
      if (osize == 0) osize = 1;
      off = rand64() % osize;
      if ($urandom_range(1))
        len = (rand64() >> $urandom_range(36, 63)) + 1;
      else
        len = (rand64() >> $urandom_range(63)) + 1;
    end else if (pick < 75) begin
      osize = ~64'($urandom_range(0, 1 << 16));
      off   = ~64'($urandom_range(0, 1 << 16));
      len   = rand64() >> $urandom_range(40, 63);
    end else if (pick < 85) begin
      if ($urandom_range(1)) begin
        off = rand64() % (osize + 1);
        len = '0;
      end else begin
        off = osize + (rand64() >> $urandom_range(63));
      end
    end
    send_request(osize, off, len);
  endtask

  initial begin
    #10_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset limits: 4 KiB blocks, 1 MiB ranges
    send_request(64'd1 << 20, 0, 0);
    send_request(1000, 1000, 1);
    send_request(1000, 5000, 10);
    send_request(0, 0, 0);
    send_request(64'd1 << 20, 0, 4096);
    send_request(64'd1 << 20, 5000, 100);
    send_request(10000, 9000, 5000);
    send_request(AllOnes, AllOnes - 99, 200);
    send_request(AllOnes, AllOnes - 10, 5);
    send_request(AllOnes, AllOnes, AllOnes);
    send_request(AllOnes, AllOnes - 1, AllOnes);
    send_request(64'd16 << 20, 0, 64'd5 << 20);
    send_request(64'd128 << 20, 0, 64'd64 << 20);
    send_request(64'd128 << 20, 0, (64'd64 << 20) + 1);
    send_request(AllOnes, 0, 64'd1 << 40);
    drain();

    set_limits(64'hFFFF_FFFF_0000_0000, 64'd1 << 20);
    send_request(64'd1 << 20, 0, 4096);
    drain();
    set_limits(4096, 0);
    send_request(64'd1 << 20, 0, 4096);
    drain();
    set_limits(8192, 4096);
    send_request(64'd1 << 20, 0, 4096);
    drain();
    set_limits(1, 1);
    send_request(1000, 10, 100);
    send_request(1000, 999, 5);
    drain();
    set_limits(3, 10);
    send_request(100, 4, 20);
    send_request(50, 44, 100);
    drain();
    set_limits(64'h0000_0000_FFFF_FFFF, AllOnes);
    send_request(AllOnes, 5, AllOnes);
    send_request(AllOnes, 64'd1 << 63, 10);
    drain();

    for (int p = 0; p < 6; p++) begin
      random_limits(p == 5 ? 3 : $urandom_range(2));
      idle_on = (p != 2);
      for (int i = 0; i < 50; i++) random_request();
      drain();
    end
    idle_on = 1'b1;

    repeat (300) @(posedge clk_i);
    if (sb.pending.size() != 0)
      sb.report($sformatf("%0d results never arrived", sb.pending.size()));
    if (sb.errors == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/brs_pkg.sv
rtl/brs_div.sv
rtl/brs_dp.sv
rtl/brs_ctrl.sv
rtl/block_aligned_range_splitter_core.sv
rtl/brs_checker.sv
dv/tb_block_aligned_range_splitter_core.sv
